[rtl/core/pda_pkg.sv]
// Shared types and constants for the pushdown automaton step block.
// No dependencies; used by pushdown_automaton_step.
package pda_pkg;

  // field widths fixed by the item formats
  localparam int ST_W       = 3;   // automaton state
  localparam int STK_SYM_W  = 2;   // stack symbol
  localparam int IN_SYM_W   = 3;   // input symbol
  localparam int CNT_W      = 2;   // push count
  localparam int KEY_W      = ST_W + STK_SYM_W + IN_SYM_W;
  localparam int DEPTH_W    = 7;   // reported stack depth
  localparam int KIND_W     = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_SYMBOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 2'd2;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_SYMBOL  = 2'd2
  } kind_t;

  // stored part of a transition entry (valid lives in flops)
  typedef struct packed {
    logic [ST_W-1:0]      next_state;
    logic [CNT_W-1:0]     push_count;
    logic [STK_SYM_W-1:0] push_first;
    logic [STK_SYM_W-1:0] push_second;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/core/pda_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; used for the transition table and the symbol stack.
module pda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/pushdown_automaton_step.sv]
// Top level of the table-driven deterministic pushdown automaton step block.
// Depends on pda_pkg and pda_ram (transition table and symbol stack memories).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in_     | slave     | in_tvalid/in_tready  | tuser: kind, tdata: entry key/fields
//   out_    | master    | out_tvalid/out_tready| tdata: status word
//   cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Load, restart and unused kinds need no read phase and may follow back to back while the output is free.
// A symbol word spends a read phase first: the transition table and the stack word below
// the top are read through registered memory ports before the update.
// Reset is synchronous; table valid flops clear at once, there is no clearing pass.
// With out_tready low the result holds and one more word waits in the input register.
module pushdown_automaton_step #(
  parameter int STACK_DEPTH = 64,
  parameter int NUM_STATES  = 8,
  parameter int PUSH_MAX    = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata, low bit up: from_state[3], top_symbol[2], symbol[3], next_state[3],
  // push_count[2], push_first[2], push_second[2], entry_valid[1], zero pad
  input  logic [pda_pkg::IN_TDATA_W-1:0]      in_tdata,
  // tuser: kind[2]
  input  logic [pda_pkg::KIND_W-1:0]          in_tuser,
  // result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata, low bit up: state_now[3], accepted[1], failed[1], stack_depth[7], zero pad
  output logic [pda_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pda_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TBL_STATES = (NUM_STATES < 8) ? NUM_STATES : 8;
  localparam int TBL_DEPTH  = TBL_STATES * 32;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int STK_AW     = $clog2(STACK_DEPTH);
  localparam int SPW        = $clog2(STACK_DEPTH + 1);
  localparam int PUSH_LIM   = (PUSH_MAX < 2) ? PUSH_MAX : 2;

  // input register
  logic                              a_valid_r;
  logic                              a_phase_r;
  pda_pkg::kind_t                    a_kind_r;
  logic [pda_pkg::ST_W-1:0]          a_from_r;
  logic [pda_pkg::STK_SYM_W-1:0]     a_top_r;
  logic [pda_pkg::IN_SYM_W-1:0]      a_sym_r;
  logic [pda_pkg::ST_W-1:0]          a_next_r;
  logic [pda_pkg::CNT_W-1:0]         a_cnt_r;
  logic [pda_pkg::STK_SYM_W-1:0]     a_first_r;
  logic [pda_pkg::STK_SYM_W-1:0]     a_second_r;
  logic                              a_evld_r;

  // automaton state
  logic [pda_pkg::ST_W-1:0]          state_r, state_nxt;
  logic [pda_pkg::STK_SYM_W-1:0]     top_r, top_nxt;
  logic [SPW-1:0]                    sp_r, sp_nxt;
  logic                              err_r, err_nxt;
  logic [TBL_DEPTH-1:0]              tbl_vld_r;

  // configuration
  logic [pda_pkg::ST_W-1:0]          start_r;
  logic [pda_pkg::STK_SYM_W-1:0]     bottom_r;
  logic [7:0]                        final_r;

  // result register
  logic                              out_valid_r;
  logic [pda_pkg::OUT_TDATA_W-1:0]   out_tdata_r;

  // memories
  logic                              tbl_we, tbl_re;
  logic [TBL_AW-1:0]                 tbl_waddr, tbl_raddr;
  pda_pkg::entry_t                   tbl_wdata, tbl_ent;
  logic [pda_pkg::ENTRY_W-1:0]       tbl_rdata;
  logic                              stk_we, stk_re;
  logic [STK_AW-1:0]                 stk_waddr, stk_raddr;
  logic [pda_pkg::STK_SYM_W-1:0]     stk_wdata, stk_rdata;

  logic                              out_free, a_is_sym, a_done, in_acc;
  logic [pda_pkg::KEY_W-1:0]         rd_key, ld_key;
  logic                              state_ok, from_ok, ent_ok, sp_ok, ovf;
  logic [pda_pkg::CNT_W-1:0]         cnt_sat;
  logic                              acc_nxt;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign a_is_sym  = (a_kind_r == pda_pkg::KIND_SYMBOL);
  assign a_done    = a_valid_r && out_free && (!a_is_sym || a_phase_r);
  assign in_tready = !a_valid_r || a_done;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // saturate the push count of a load word
  assign cnt_sat = (32'(in_tdata[12:11]) > 32'(PUSH_LIM)) ? pda_pkg::CNT_W'(PUSH_LIM)
                                                          : in_tdata[12:11];

  // input register, symbol words spend a read phase here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_phase_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
      a_phase_r <= 1'b0;
    end else if (a_done) begin
      a_valid_r <= 1'b0;
      a_phase_r <= 1'b0;
    end else if (a_valid_r && a_is_sym) begin
      a_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_kind_r   <= pda_pkg::kind_t'(in_tuser);
      a_from_r   <= in_tdata[2:0];
      a_top_r    <= in_tdata[4:3];
      a_sym_r    <= in_tdata[7:5];
      a_next_r   <= in_tdata[10:8];
      a_cnt_r    <= cnt_sat;
      a_first_r  <= in_tdata[14:13];
      a_second_r <= in_tdata[16:15];
      a_evld_r   <= in_tdata[17];
    end
  end

  // table and stack read addresses, issued in the first phase of a symbol word
  assign rd_key    = {state_r, top_r, a_sym_r};
  assign ld_key    = {a_from_r, a_top_r, a_sym_r};
  assign tbl_re    = a_valid_r && a_is_sym && !a_phase_r;
  assign tbl_raddr = rd_key[TBL_AW-1:0];
  assign stk_re    = tbl_re;
  assign stk_raddr = STK_AW'(sp_r - SPW'(2));

  assign tbl_waddr = ld_key[TBL_AW-1:0];
  assign tbl_wdata = '{next_state: a_next_r, push_count: a_cnt_r,
                       push_first: a_first_r, push_second: a_second_r};
  assign tbl_ent   = pda_pkg::entry_t'(tbl_rdata);

  // checks on the looked-up transition
  assign state_ok = 32'(state_r) < 32'(NUM_STATES);
  assign from_ok  = 32'(a_from_r) < 32'(NUM_STATES);
  assign ent_ok   = state_ok && tbl_vld_r[tbl_raddr];
  assign sp_ok    = (sp_r != '0) && (32'(sp_r) <= 32'(STACK_DEPTH));
  assign ovf      = (32'(sp_r) + 32'(tbl_ent.push_count)) > 32'(STACK_DEPTH + 1);

  // next automaton state
  always_comb begin
    state_nxt = state_r;
    top_nxt   = top_r;
    sp_nxt    = sp_r;
    err_nxt   = err_r;
    tbl_we    = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = STK_AW'(sp_r - SPW'(1));
    stk_wdata = tbl_ent.push_first;
    if (a_done) begin
      unique case (a_kind_r)
        pda_pkg::KIND_LOAD: begin
          tbl_we = from_ok;
        end
        pda_pkg::KIND_RESTART: begin
          state_nxt = start_r;
          top_nxt   = bottom_r;
          sp_nxt    = SPW'(1);
          err_nxt   = 1'b0;
        end
        pda_pkg::KIND_SYMBOL: begin
          priority if (err_r) begin
            err_nxt = 1'b1;
          end else if (!sp_ok || !ent_ok || ovf) begin
            err_nxt = 1'b1;
          end else begin
            state_nxt = tbl_ent.next_state;
            // top lives in a register, the memory holds the words below it
            unique case (tbl_ent.push_count)
              2'd1: begin
                top_nxt = tbl_ent.push_first;
              end
              2'd2: begin
                stk_we  = 1'b1;
                top_nxt = tbl_ent.push_second;
                sp_nxt  = sp_r + SPW'(1);
              end
              default: begin
                top_nxt = stk_rdata;
                sp_nxt  = sp_r - SPW'(1);
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign acc_nxt = !err_nxt && (sp_nxt != '0) && final_r[state_nxt] && (top_nxt == bottom_r);

  // state registers and table valid flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      top_r     <= '0;
      sp_r      <= SPW'(1);
      err_r     <= 1'b0;
      tbl_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      sp_r    <= sp_nxt;
      err_r   <= err_nxt;
      if (tbl_we) begin
        tbl_vld_r[tbl_waddr] <= a_evld_r;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      bottom_r <= '0;
      final_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pda_pkg::CFG_START_STATE:   start_r  <= cfg_data[2:0];
        pda_pkg::CFG_BOTTOM_SYMBOL: bottom_r <= cfg_data[1:0];
        pda_pkg::CFG_FINAL_MASK:    final_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_done) begin
      out_tdata_r <= {4'b0, pda_pkg::DEPTH_W'(sp_nxt), err_nxt, acc_nxt, state_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // transition table memory
  pda_ram #(
    .WIDTH (pda_pkg::ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // symbol stack memory, words below the top
  pda_ram #(
    .WIDTH (pda_pkg::STK_SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // read phase belongs to a symbol word only
  assert property (@(posedge clk) disable iff (!rst_n)
    a_phase_r |-> (a_valid_r && a_kind_r == pda_pkg::KIND_SYMBOL))
    else $error("read phase without a symbol word");

  // stack pointer stays within the stack
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= 32'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // a push into memory never lands past the end of the stack
  assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> (32'(sp_r) < 32'(STACK_DEPTH)))
    else $error("stack write past the end");

  // error is sticky until a restart
  assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !(a_done && a_kind_r == pda_pkg::KIND_RESTART)) |=> err_r)
    else $error("error flag cleared without restart");

  // restart leaves one clean stack word
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_done && a_kind_r == pda_pkg::KIND_RESTART) |=> (!err_r && sp_r == SPW'(1)))
    else $error("restart did not reset the stack");

endmodule
